// ===== sv/touch_adc_serial_interface_macros.svh =====
// ----------------------------------------------------------------------------
// Touch converter serial interface assertion macros
// Shared concurrent assertion forms used by the serial interface RTL.
// ----------------------------------------------------------------------------
`ifndef TOUCH_ADC_SERIAL_INTERFACE_MACROS_SVH
`define TOUCH_ADC_SERIAL_INTERFACE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define TASI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define TASI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tasi_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch converter serial interface package
// Widths, codes and shared types of the serial interface.
// ----------------------------------------------------------------------------
package tasi_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SHIFT_BITS  = SAMPLE_BITS + 1;
  localparam int CMD_BITS    = 8;
  localparam int CMD_CNT_W   = 4;
  localparam int EIGHT_BITS  = 8;

  // Command byte layout.
  localparam int CMD_SINGLE_POS = 2;
  localparam int CMD_EIGHT_POS  = 3;
  localparam int CMD_CHAN_LSB   = 4;
  localparam int CMD_CHAN_MSB   = 6;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SHIFT_BITS-1:0]  reply_t;
  typedef logic [CMD_BITS-1:0]    cmd_t;
  typedef logic [CMD_CNT_W-1:0]   cmd_cnt_t;

  localparam sample_t FULL_SCALE = {SAMPLE_BITS{1'b1}};
  // Keeps the top eight bits of a sample in place.
  localparam sample_t EIGHT_MASK = {{EIGHT_BITS{1'b1}}, {(SAMPLE_BITS-EIGHT_BITS){1'b0}}};
  localparam cmd_cnt_t CMD_LAST  = cmd_cnt_t'(CMD_BITS);

  typedef enum logic [1:0] {
    KIND_SELECT = 2'd0,
    KIND_CLOCK  = 2'd1,
    KIND_PEN    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_TEMP_LOW  = 2'd0,
    CFG_TEMP_HIGH = 2'd1,
    CFG_AUX       = 2'd2,
    CFG_BATTERY   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CH_TEMP_LOW  = 3'd0,
    CH_Y         = 3'd1,
    CH_BATTERY   = 3'd2,
    CH_Z1        = 3'd3,
    CH_Z2        = 3'd4,
    CH_X         = 3'd5,
    CH_AUX       = 3'd6,
    CH_TEMP_HIGH = 3'd7
  } chan_e;

  // Everything the reply multiplexer can return.
  typedef struct packed {
    sample_t temp_low;
    sample_t temp_high;
    sample_t aux;
    sample_t battery;
    sample_t pos_x;
    sample_t pos_y;
    sample_t press_one;
    sample_t press_two;
  } sample_src_t;

  // Per-request strobes from the top level into the serial engine.
  typedef struct packed {
    logic bit_en;
    logic sel_clear;
    logic data_bit;
  } serial_ctl_t;

endpackage

// ===== sv/tasi_sample_sel.sv =====
// ----------------------------------------------------------------------------
// Touch converter sample selector
// Decodes a command byte into the sample code that the reply carries.
// ----------------------------------------------------------------------------
module tasi_sample_sel
  import tasi_pkg::*;
(
  input  cmd_t        cmd_i,
  input  sample_src_t src_i,
  output sample_t     sample_o
);

  chan_e   chan;
  logic    single;
  sample_t raw;

  assign chan   = chan_e'(cmd_i[CMD_CHAN_MSB:CMD_CHAN_LSB]);
  assign single = cmd_i[CMD_SINGLE_POS];

  // Differential mode only reaches the touch channels.
  always_comb begin
    unique case (chan)
      CH_TEMP_LOW:  raw = single ? src_i.temp_low : '0;
      CH_Y:         raw = src_i.pos_y;
      CH_BATTERY:   raw = single ? src_i.battery : '0;
      CH_Z1:        raw = src_i.press_one;
      CH_Z2:        raw = src_i.press_two;
      CH_X:         raw = src_i.pos_x;
      CH_AUX:       raw = single ? src_i.aux : '0;
      CH_TEMP_HIGH: raw = single ? src_i.temp_high : '0;
      default:      raw = '0;
    endcase
  end

  assign sample_o = cmd_i[CMD_EIGHT_POS] ? (raw & EIGHT_MASK) : raw;

endmodule

// ===== sv/tasi_serial.sv =====
// ----------------------------------------------------------------------------
// Touch converter serial engine
// Command byte shifter and reply shifter, one host bit per request.
// ----------------------------------------------------------------------------
module tasi_serial
  import tasi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  serial_ctl_t ctl_i,
  input  sample_src_t src_i,
  output logic        data_out_o
);

  cmd_t     cmd_q, cmd_d, cmd_next;
  cmd_cnt_t cnt_q, cnt_d, cnt_next;
  logic     started_q, started_d;
  reply_t   reply_q, reply_d;
  logic     take_bit;
  logic     done;
  sample_t  sample;

  // A one bit opens a command; once open, every bit is taken.
  assign take_bit = ctl_i.bit_en && (started_q || ctl_i.data_bit);
  assign cmd_next = {cmd_q[CMD_BITS-2:0], ctl_i.data_bit};
  assign cnt_next = (started_q ? cnt_q : '0) + cmd_cnt_t'(1);
  assign done     = take_bit && (cnt_next == CMD_LAST);

  tasi_sample_sel u_sample_sel (
    .cmd_i    (cmd_next),
    .src_i    (src_i),
    .sample_o (sample)
  );

  always_comb begin
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    started_d  = started_q;
    reply_d    = reply_q;
    data_out_o = 1'b0;
    if (ctl_i.sel_clear) begin
      cmd_d = '0;
      cnt_d = '0;
    end
    if (take_bit) begin
      cmd_d     = cmd_next;
      cnt_d     = cnt_next;
      started_d = !done;
    end
    if (ctl_i.bit_en) begin
      // When a command completes, a zero is sent and the sample is loaded, MSB first.
      if (done) begin
        data_out_o = 1'b0;
        reply_d    = {sample, 1'b0};
      end else begin
        data_out_o = reply_q[SHIFT_BITS-1];
        reply_d    = {reply_q[SHIFT_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= '0;
      cnt_q     <= '0;
      started_q <= 1'b0;
      reply_q   <= '0;
    end else begin
      cmd_q     <= cmd_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
      reply_q   <= reply_d;
    end
  end

endmodule

// ===== sv/touch_adc_serial_interface.sv =====
// ----------------------------------------------------------------------------
// Touch converter serial interface
// Host-side serial port and pen state of a touch-screen converter.
// ----------------------------------------------------------------------------
// Each input request carries one event: a chip-select change, one serial bit
// clock from the host, or a pen position update. Every request yields exactly
// one result request with the bit sent to the host and the pen-down line.
// Input and output channels use valid/ready. The configuration port is a
// plain write port (enable, index, data) for the four fixed channel codes;
// the user must write it only while no request is in flight; not enforced.
// The result of a request is registered in the output register and can be
// seen from the cycle after the request is accepted. Throughput is one request
// per cycle while the receiver takes each result; all command and reply state
// updates in the cycle of acceptance, so the next request sees it at once.
// The output register is the only buffer. While the receiver stalls with a
// result pending, in_ready_o stays low; when the result is taken, a new
// request can enter in the same cycle.
// Reset clears the command and reply shifters, the pen codes and the channel
// codes, deselects the port and drives the pen line high (pen up).
// ----------------------------------------------------------------------------
`include "touch_adc_serial_interface_macros.svh"

module touch_adc_serial_interface
  import tasi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i,
  // Input requests.
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             kind_i,
  input  logic                   select_level_i,
  input  logic                   data_bit_i,
  input  logic [SAMPLE_BITS-1:0] pen_x_i,
  input  logic [SAMPLE_BITS-1:0] pen_y_i,
  input  logic [SAMPLE_BITS-1:0] pen_pressure_i,
  // Result requests.
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   data_out_o,
  output logic                   pen_irq_n_o
);

  // Channel codes written by the host.
  sample_t temp_low_q, temp_high_q, aux_q, battery_q;
  // Pen state.
  sample_t pos_x_q, pos_y_q, press_one_q, press_two_q;
  logic    pen_line_q, pen_line_d;
  logic    sel_q;
  // Result register.
  logic    out_valid_q, data_out_q, pen_irq_n_q;

  logic        in_fire;
  kind_e       kind;
  logic        pen_fire;
  logic        serial_bit;
  serial_ctl_t ctl;
  sample_src_t src;

  // The result register parts both sides: a new request enters whenever the
  // register is empty or is being emptied in this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign kind       = kind_e'(kind_i);

  always_comb begin
    ctl      = '0;
    pen_fire = 1'b0;
    ctl.data_bit = data_bit_i;
    if (in_fire) begin
      case (kind)
        KIND_SELECT: ctl.sel_clear = select_level_i;
        KIND_CLOCK:  ctl.bit_en    = sel_q;
        KIND_PEN:    pen_fire      = 1'b1;
        default:     ctl           = '0;
      endcase
    end
  end

  // Pen line goes low exactly when a nonzero pressure is reported.
  assign pen_line_d = pen_fire ? (pen_pressure_i == '0) : pen_line_q;

  assign src = '{
    temp_low:  temp_low_q,
    temp_high: temp_high_q,
    aux:       aux_q,
    battery:   battery_q,
    pos_x:     pos_x_q,
    pos_y:     pos_y_q,
    press_one: press_one_q,
    press_two: press_two_q
  };

  tasi_serial u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .src_i      (src),
    .data_out_o (serial_bit)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_low_q  <= '0;
      temp_high_q <= '0;
      aux_q       <= '0;
      battery_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TEMP_LOW:  temp_low_q  <= cfg_data_i;
        CFG_TEMP_HIGH: temp_high_q <= cfg_data_i;
        CFG_AUX:       aux_q       <= cfg_data_i;
        CFG_BATTERY:   battery_q   <= cfg_data_i;
        default:       temp_low_q  <= temp_low_q;
      endcase
    end
  end

  // Chip select and pen state. Deselecting only drops the select flag; the
  // serial engine clears its command shifter on selection.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      press_one_q <= '0;
      press_two_q <= '0;
      pen_line_q  <= 1'b1;
    end else begin
      if (in_fire && (kind == KIND_SELECT)) begin
        sel_q <= select_level_i;
      end
      if (pen_fire) begin
        pos_x_q     <= pen_x_i;
        pos_y_q     <= pen_y_i;
        press_one_q <= pen_pressure_i;
        press_two_q <= FULL_SCALE - pen_pressure_i;
      end
      pen_line_q <= pen_line_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      data_out_q  <= 1'b0;
      pen_irq_n_q <= 1'b1;
    end else begin
      if (in_fire) begin
        out_valid_q <= 1'b1;
        data_out_q  <= serial_bit;
        pen_irq_n_q <= pen_line_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;
  assign pen_irq_n_o = pen_irq_n_q;

  // A stalled result must block new requests.
  `TASI_ASSERT_SAME(a_stall_blocks, clk_i, rst_ni, out_valid_q && !out_ready_i,
                    !in_ready_o, "request accepted over a stalled result")
  // Only a bit clock can put a one on the host data line.
  `TASI_ASSERT_NEXT(a_data_only_clock, clk_i, rst_ni, in_fire && (kind_i != KIND_CLOCK),
                    out_valid_o && !data_out_o, "data bit driven outside a bit clock")
  // A touching pen pulls the pen line low in its own result.
  `TASI_ASSERT_NEXT(a_pen_down, clk_i, rst_ni,
                    in_fire && (kind_i == KIND_PEN) && (pen_pressure_i != '0),
                    out_valid_o && !pen_irq_n_o, "pen down not reported")
  // Deselecting drops the select flag.
  `TASI_ASSERT_NEXT(a_deselect, clk_i, rst_ni,
                    in_fire && (kind_i == KIND_SELECT) && !select_level_i,
                    !sel_q, "port still selected after deselect")

endmodule
